### hdl/slid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert/delete - shared definitions
// Sizes, request and status codes and the transaction types passed between
// the front queue, the cell row and the result queue.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_DELETE  = 2'd1;
    localparam logic [1:0] REQ_POP_MIN = 2'd2;
    localparam logic [1:0] REQ_POP_MAX = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] removed_value;
        logic [CNT_W-1:0]        entry_count;
    } t_res;

endpackage
`default_nettype wire

### hdl/slid_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert/delete - request front end
// Accepts request transactions, decodes the request type into a command and
// holds up to two commands for the cell row, so each side stalls on its own.
// ----------------------------------------------------------------------------
module slid_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [1:0]      i_req_type,
    input  wire logic [31:0]     i_value,
    output logic                 o_cmd_valid,
    output slid_pkg::t_cmd       o_cmd,
    input  wire logic            i_cmd_take
);
    import slid_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_cmd       w_new;
    logic       w_wr;
    logic       w_rd;

    always_comb begin
        w_new.value = i_value;
        case (i_req_type)
            REQ_INSERT:  w_new.op = REQ_INSERT;
            REQ_DELETE:  w_new.op = REQ_DELETE;
            REQ_POP_MIN: w_new.op = REQ_POP_MIN;
            default:     w_new.op = REQ_POP_MAX;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign w_wr        = push && !full;
    assign w_rd        = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_wr) r_wr_ptr <= !r_wr_ptr;
            if (w_rd) r_rd_ptr <= !r_rd_ptr;
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_slot[r_wr_ptr] <= w_new;
    end

endmodule
`default_nettype wire

### hdl/slid_cells.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert/delete - compare-and-shift cell row
// One register per list position. Every cell compares its entry with the
// command value and takes its own value, the request value or a neighbour's
// value, so every cell is updated for a command at once.
// ----------------------------------------------------------------------------
module slid_cells (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cmd_valid,
    input  wire slid_pkg::t_cmd           i_cmd,
    output logic                          o_cmd_take,
    input  wire logic                     i_res_full,
    output logic                          o_res_push,
    output slid_pkg::t_res                o_res,
    output logic [slid_pkg::CNT_W-1:0]    o_count
);
    import slid_pkg::*;

    logic signed [VAL_W-1:0] r_entry [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic                    w_go;
    logic                    w_found;
    logic                    w_is_empty;
    logic                    w_is_full;
    logic [IDX_W-1:0]        w_last_idx;
    logic [1:0]              w_status;
    logic signed [VAL_W-1:0] w_removed;

    assign w_go       = i_cmd_valid && !i_res_full;
    assign o_cmd_take = w_go;
    assign o_res_push = w_go;
    assign w_found    = |w_eq;
    assign w_is_empty = (r_count == '0);
    assign w_is_full  = (r_count == CNT_W'(CAPACITY));
    assign w_last_idx = IDX_W'(r_count - CNT_W'(1));
    assign o_count    = r_count;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_prev_lt;
        logic signed [VAL_W-1:0] w_prev;
        logic signed [VAL_W-1:0] w_next;
        logic signed [VAL_W-1:0] n_entry;

        assign w_lt[g] = (CNT_W'(g) < r_count) && (r_entry[g] < i_cmd.value);
        assign w_eq[g] = (CNT_W'(g) < r_count) && (r_entry[g] == i_cmd.value);

        // The first cell behaves as if an entry below the request value sat
        // in front of it, so an insert at the head lands there.
        if (g == 0) begin : g_first
            assign w_prev_lt = 1'b1;
            assign w_prev    = i_cmd.value;
        end else begin : g_inner
            assign w_prev_lt = w_lt[g-1];
            assign w_prev    = r_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = r_entry[g];
        end else begin : g_mid
            assign w_next = r_entry[g+1];
        end

        always_comb begin
            n_entry = r_entry[g];
            case (i_cmd.op)
                REQ_INSERT: begin
                    if (!w_is_full && !w_lt[g]) n_entry = w_prev_lt ? i_cmd.value : w_prev;
                end
                REQ_DELETE: begin
                    // Entries are sorted, so the first equal entry is the
                    // first one not below the value.
                    if (w_found && !w_lt[g]) n_entry = w_next;
                end
                REQ_POP_MIN: begin
                    if (!w_is_empty) n_entry = w_next;
                end
                default: begin
                    n_entry = r_entry[g];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_go) r_entry[g] <= n_entry;
        end
    end

    always_comb begin
        w_status  = ST_OK;
        w_removed = '0;
        n_count   = r_count;
        case (i_cmd.op)
            REQ_INSERT: begin
                if (w_is_full) w_status = ST_FULL;
                else           n_count  = r_count + CNT_W'(1);
            end
            REQ_DELETE: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_found) begin
                    w_removed = i_cmd.value;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            REQ_POP_MIN: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_removed = r_entry[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (w_is_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_removed = r_entry[w_last_idx];
                    n_count   = r_count - CNT_W'(1);
                end
            end
        endcase
    end

    assign o_res.status        = w_status;
    assign o_res.removed_value = w_removed;
    assign o_res.entry_count   = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_go) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### hdl/slid_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert/delete - result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module slid_resq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_res_push,
    input  wire slid_pkg::t_res i_res,
    output logic             o_res_full,
    output logic             empty,
    input  wire logic        pop,
    output slid_pkg::t_res   o_head
);
    import slid_pkg::*;

    t_res       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_res_full = (r_cnt == 2'd2);
    assign empty      = (r_cnt == 2'd0);
    assign o_head     = r_slot[r_rd_ptr];
    assign w_wr       = i_res_push && !o_res_full;
    assign w_rd       = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_wr) r_wr_ptr <= !r_wr_ptr;
            if (w_rd) r_rd_ptr <= !r_rd_ptr;
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_slot[r_wr_ptr] <= i_res;
    end

endmodule
`default_nettype wire

### hdl/sorted_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert/delete - top level
// Bounded ascending list of signed values with insert, delete, remove
// smallest and remove largest requests, one status result per request.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the request queue is
// not full, and returns one result per request, in order. A request is
// registered in the request queue, and its result is registered in the
// result queue before it shows on the result ports. The rate is set by the
// compare-and-shift cell row, which places or removes an entry for each
// command it takes; two-entry queues on the request and result sides let
// either side stall without the other. No clearing pass is needed after reset.
module sorted_list_insert_delete (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_status,
    output logic [31:0]      o_removed_value,
    output logic [4:0]       o_entry_count
);
    import slid_pkg::*;

    logic             w_cmd_valid;
    t_cmd             w_cmd;
    logic             w_cmd_take;
    logic             w_res_full;
    logic             w_res_push;
    t_res             w_res;
    t_res             w_head;
    logic [CNT_W-1:0] w_count;

    slid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    slid_cells u_cells (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .o_count     (w_count)
    );

    slid_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (w_res_push),
        .i_res      (w_res),
        .o_res_full (w_res_full),
        .empty      (empty),
        .pop        (pop),
        .o_head     (w_head)
    );

    assign o_status        = w_head.status;
    assign o_removed_value = w_head.removed_value;
    assign o_entry_count   = 5'(w_head.entry_count);

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && (w_res.status == ST_FULL) |-> w_count == CNT_W'(CAPACITY))
        else $error("full status reported on a list that is not full");

    a_empty_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push && (w_res.status == ST_EMPTY) |-> w_count == '0)
        else $error("empty status reported on a list that holds entries");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_take && (w_cmd.op == REQ_INSERT) && (w_count != CNT_W'(CAPACITY))
        |=> w_count == $past(w_count) + CNT_W'(1))
        else $error("accepted insert did not grow the list by one");
`endif

endmodule
`default_nettype wire
